// ===== rtl/ccq_pkg.sv =====
// Shared types, constants and helpers for the coalescing CAN transmit queue.
// No dependencies; imported by every module of the block.
package ccq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 11;
  localparam int ID_COUNT    = 2048;
  localparam int LEN_W       = 4;
  localparam int DATA_W      = 64;
  localparam int RET_W       = 4;
  localparam int BACK_W      = 7;
  localparam int MEM_W       = 1 + LEN_W + DATA_W;

  localparam logic [LEN_W-1:0] MAX_BYTES       = 4'd8;
  localparam logic [2:0]       BACKOFF_EXP_MAX = 3'd6;

  typedef enum logic [1:0] {
    CMD_SUBMIT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_STATUS = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    WS_OK    = 2'd0,
    WS_RETRY = 2'd1,
    WS_FATAL = 2'd2,
    WS_BAD   = 2'd3
  } wstat_e;

  typedef enum logic [3:0] {
    RC_ACCEPTED   = 4'd0,
    RC_BAD_LENGTH = 4'd1,
    RC_EMPTY      = 4'd2,
    RC_POPPED     = 4'd3,
    RC_SENT       = 4'd4,
    RC_REQUEUED   = 4'd5,
    RC_SUPERSEDED = 4'd6,
    RC_RETRY_LIM  = 4'd7,
    RC_FATAL      = 4'd8,
    RC_NO_FLIGHT  = 4'd9
  } rc_e;

  typedef enum logic [2:0] {
    OP_SUBMIT,
    OP_BADLEN,
    OP_POP,
    OP_STATUS,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RETRY,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   len;
    logic [DATA_W-1:0]  payload;
    wstat_e             wstat;
  } req_t;

  typedef struct packed {
    rc_e                code;
    logic               evicted;
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   len;
    logic [DATA_W-1:0]  payload;
    logic [RET_W-1:0]   retries;
    logic [BACK_W-1:0]  backoff;
  } res_t;

  typedef struct packed {
    logic               clearing;
    logic [CW-1:0]      q_count;
  } stat_t;

  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] m;
    if (len >= MAX_BYTES) m = '1;
    else m = (DATA_W'(1) << {len[2:0], 3'b000}) - DATA_W'(1);
    return m;
  endfunction

endpackage

// ===== rtl/ccq_front.sv =====
// Front end: takes requests, classifies them and holds them in a two-entry queue.
// Depends on ccq_pkg.
module ccq_front import ccq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        command_i,
  input  logic [ID_W-1:0]   can_id_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic [DATA_W-1:0] payload_i,
  input  logic [1:0]        write_status_i,
  output logic              in_stall_o,
  input  logic              clearing_i,
  output logic              req_valid_o,
  output req_t              req_o,
  input  logic              req_pop_i
);

  req_t       ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  req_t       cls;
  logic       push, pop;

  always_comb begin
    cls         = '0;
    cls.id      = can_id_i;
    cls.len     = length_i;
    cls.payload = payload_i & byte_mask(length_i);
    cls.wstat   = wstat_e'(write_status_i);
    unique case (cmd_e'(command_i))
      CMD_SUBMIT: cls.op = (length_i > MAX_BYTES) ? OP_BADLEN : OP_SUBMIT;
      CMD_POP:    cls.op = OP_POP;
      CMD_STATUS: cls.op = OP_STATUS;
      default:    cls.op = OP_NONE;
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2) || clearing_i;
  assign push        = in_valid_i && !in_stall_o;
  assign req_valid_o = (cnt_q != 2'd0);
  assign pop         = req_pop_i && req_valid_o;
  assign req_o       = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_ptr_q] <= cls;
  end

endmodule

// ===== rtl/ccq_back.sv =====
// Back end: latest-frame table, coalescing frame queue, in-flight frame and result register.
// Depends on ccq_pkg.
module ccq_back import ccq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  req_t              req_i,
  output logic              req_pop_o,
  input  logic [RET_W-1:0]  retry_limit_i,
  input  logic [BACK_W-1:0] backoff_cap_i,
  output logic              out_valid_o,
  output res_t              out_o,
  input  logic              out_stall_i,
  output stat_t             stat_o
);

  state_e state_q, state_d;

  // latest-frame table: {valid, length, payload}
  logic [MEM_W-1:0] mem [ID_COUNT];
  logic [MEM_W-1:0] rd_q;
  logic             mem_we;
  logic [ID_W-1:0]  mem_waddr;
  logic [MEM_W-1:0] mem_wdata;
  logic [ID_W-1:0]  clr_cnt_q;

  // queue, head at index 0
  logic [ID_W-1:0]   q_id_q  [QUEUE_DEPTH];
  logic [LEN_W-1:0]  q_len_q [QUEUE_DEPTH];
  logic [DATA_W-1:0] q_pay_q [QUEUE_DEPTH];
  logic [RET_W-1:0]  q_ret_q [QUEUE_DEPTH];
  logic [CW-1:0]     q_cnt_q;

  logic              fl_valid_q;
  logic [ID_W-1:0]   fl_id_q;
  logic [LEN_W-1:0]  fl_len_q;
  logic [DATA_W-1:0] fl_pay_q;
  logic [RET_W-1:0]  fl_ret_q;

  req_t cur_q;
  res_t res_q, res_d;
  res_t out_q;
  logic out_valid_q;

  // search / update controls
  logic [ID_W-1:0]   key;
  logic              hit;
  logic [QW-1:0]     hit_pos;
  logic              full;
  logic              rm_en, app_en, fl_load, fl_clear;
  logic [QW-1:0]     rm_pos, app_idx;
  logic [ID_W-1:0]   app_id;
  logic [LEN_W-1:0]  app_len;
  logic [DATA_W-1:0] app_pay;
  logic [RET_W-1:0]  app_ret;
  logic [CW-1:0]     cnt_rm;
  logic [RET_W-1:0]  fret1;
  logic [2:0]        bexp;
  logic [BACK_W-1:0] bpow;
  logic              still_latest;
  logic              out_load;

  assign full = (q_cnt_q == CW'(QUEUE_DEPTH));

  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if ((CW'(i) < q_cnt_q) && (q_id_q[i] == key)) begin
        hit     = 1'b1;
        hit_pos = QW'(i);
      end
    end
  end

  assign fret1 = fl_ret_q + RET_W'(1);
  assign bexp  = (fret1 > RET_W'(BACKOFF_EXP_MAX)) ? BACKOFF_EXP_MAX : fret1[2:0];
  assign bpow  = BACK_W'(1) << bexp;
  assign still_latest = rd_q[MEM_W-1] && (rd_q[MEM_W-2 -: LEN_W] == fl_len_q) &&
                        (rd_q[DATA_W-1:0] == fl_pay_q) && !hit;
  assign out_load = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_cnt_q == ID_W'(ID_COUNT - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (req_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        if (cur_q.op == OP_STATUS && fl_valid_q && cur_q.wstat == WS_RETRY &&
            fl_ret_q < retry_limit_i) state_d = ST_RETRY;
        else state_d = ST_OUT;
      end
      ST_RETRY: state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // controls
  always_comb begin
    req_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_q;
    mem_wdata = '0;
    key       = cur_q.id;
    rm_en     = 1'b0;
    rm_pos    = '0;
    app_en    = 1'b0;
    app_id    = cur_q.id;
    app_len   = cur_q.len;
    app_pay   = cur_q.payload;
    app_ret   = '0;
    fl_load   = 1'b0;
    fl_clear  = 1'b0;
    res_d     = res_q;
    unique case (state_q)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE:  req_pop_o = req_valid_i;
      ST_EXEC: begin
        res_d      = '0;
        res_d.code = RC_NO_FLIGHT;
        unique case (cur_q.op)
          OP_BADLEN: res_d.code = RC_BAD_LENGTH;
          OP_SUBMIT: begin
            mem_we        = 1'b1;
            mem_waddr     = cur_q.id;
            mem_wdata     = {1'b1, cur_q.len, cur_q.payload};
            rm_en         = hit || full;
            rm_pos        = hit ? hit_pos : '0;
            app_en        = 1'b1;
            res_d.evicted = !hit && full;
            res_d.code    = RC_ACCEPTED;
          end
          OP_POP: begin
            if (q_cnt_q == '0) begin
              res_d.code = RC_EMPTY;
            end else begin
              rm_en         = 1'b1;
              fl_load       = 1'b1;
              res_d.code    = RC_POPPED;
              res_d.id      = q_id_q[0];
              res_d.len     = q_len_q[0];
              res_d.payload = q_pay_q[0];
              res_d.retries = q_ret_q[0];
            end
          end
          OP_STATUS: begin
            if (fl_valid_q) begin
              fl_clear = 1'b1;
              case (cur_q.wstat)
                WS_OK:    res_d.code = RC_SENT;
                WS_RETRY: res_d.code = (fl_ret_q < retry_limit_i) ? RC_SUPERSEDED
                                                                  : RC_RETRY_LIM;
                default:  res_d.code = RC_FATAL;
              endcase
            end
          end
          default: res_d.code = RC_NO_FLIGHT;
        endcase
      end
      ST_RETRY: begin
        key           = fl_id_q;
        res_d.backoff = (bpow < backoff_cap_i) ? bpow : backoff_cap_i;
        if (still_latest) begin
          rm_en         = full;
          app_en        = 1'b1;
          app_id        = fl_id_q;
          app_len       = fl_len_q;
          app_pay       = fl_pay_q;
          app_ret       = fret1;
          res_d.evicted = full;
          res_d.code    = RC_REQUEUED;
        end else begin
          res_d.code = RC_SUPERSEDED;
        end
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  assign cnt_rm  = q_cnt_q - CW'(rm_en);
  assign app_idx = QW'(cnt_rm);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      q_cnt_q     <= '0;
      fl_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + ID_W'(1);
      q_cnt_q <= cnt_rm + CW'(app_en);
      if (fl_load)       fl_valid_q <= 1'b1;
      else if (fl_clear) fl_valid_q <= 1'b0;
      if (state_q == ST_OUT && out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i)             out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (app_en && app_idx == QW'(i)) begin
        q_id_q[i]  <= app_id;
        q_len_q[i] <= app_len;
        q_pay_q[i] <= app_pay;
        q_ret_q[i] <= app_ret;
      end else if (rm_en && QW'(i) >= rm_pos && i < QUEUE_DEPTH - 1) begin
        q_id_q[i]  <= q_id_q[(i + 1) % QUEUE_DEPTH];
        q_len_q[i] <= q_len_q[(i + 1) % QUEUE_DEPTH];
        q_pay_q[i] <= q_pay_q[(i + 1) % QUEUE_DEPTH];
        q_ret_q[i] <= q_ret_q[(i + 1) % QUEUE_DEPTH];
      end
    end
    if (req_pop_o) cur_q <= req_i;
    res_q <= res_d;
    if (fl_load) begin
      fl_id_q  <= q_id_q[0];
      fl_len_q <= q_len_q[0];
      fl_pay_q <= q_pay_q[0];
      fl_ret_q <= q_ret_q[0];
    end
    if (state_q == ST_OUT && out_load) out_q <= res_q;
  end

  // table port: one write, one registered read at the in-flight identifier
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[fl_id_q];
  end

  assign out_valid_o     = out_valid_q;
  assign out_o           = out_q;
  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign stat_o.q_count  = q_cnt_q;

endmodule

// ===== rtl/coalescing_can_tx_queue_unit.sv =====
// Top level of the coalescing CAN transmit queue: APB registers, front and back ends.
// Depends on ccq_pkg, ccq_front and ccq_back.
// After reset the block clears its per-identifier table and holds
// in_stall_o high meanwhile (register writes are taken). Each request then goes through the
// back-end states take, execute and result; a retry report within the limit also goes through a
// retry state, which needs a registered read of the latest-frame table; one result comes out
// per request, and a two-entry request queue plus the result register let both sides stall on their own.
module coalescing_can_tx_queue_unit import ccq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  input  logic [ID_W-1:0]   can_id_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic [DATA_W-1:0] payload_i,
  input  logic [1:0]        write_status_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        result_code_o,
  output logic              evicted_oldest_o,
  output logic [ID_W-1:0]   out_id_o,
  output logic [LEN_W-1:0]  out_length_o,
  output logic [DATA_W-1:0] out_payload_o,
  output logic [RET_W-1:0]  out_retries_o,
  output logic [BACK_W-1:0] retry_wait_o
);

  logic [RET_W-1:0]  retry_limit_q;
  logic [BACK_W-1:0] backoff_cap_q;
  logic              req_valid, req_pop;
  req_t              req;
  res_t              res;
  stat_t             stat;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q <= RET_W'(3);
      backoff_cap_q <= BACK_W'(64);
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) backoff_cap_q <= pwdata[BACK_W-1:0];
      else          retry_limit_q <= pwdata[RET_W-1:0];
    end
  end

  assign prdata = paddr[2] ? {25'd0, backoff_cap_q} : {28'd0, retry_limit_q};

  ccq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .command_i, .can_id_i, .length_i, .payload_i,
    .write_status_i, .in_stall_o,
    .clearing_i  (stat.clearing),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_pop_i   (req_pop)
  );

  ccq_back u_back (
    .clk_i, .rst_ni,
    .req_valid_i   (req_valid),
    .req_i         (req),
    .req_pop_o     (req_pop),
    .retry_limit_i (retry_limit_q),
    .backoff_cap_i (backoff_cap_q),
    .out_valid_o,
    .out_o         (res),
    .out_stall_i,
    .stat_o        (stat)
  );

  assign result_code_o    = res.code;
  assign evicted_oldest_o = res.evicted;
  assign out_id_o         = res.id;
  assign out_length_o     = res.len;
  assign out_payload_o    = res.payload;
  assign out_retries_o    = res.retries;
  assign retry_wait_o     = res.backoff;

  a_no_req_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> in_stall_o) else $error("request taken during table clear");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.q_count <= CW'(QUEUE_DEPTH)) else $error("queue count over depth");

  a_frame_only_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res.code != RC_POPPED) |-> (out_id_o == '0 && out_length_o == '0))
    else $error("frame fields set on non-pop result");

  a_backoff_only_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && res.code != RC_REQUEUED && res.code != RC_SUPERSEDED)
      |-> retry_wait_o == '0) else $error("backoff set without retry");

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for the coalescing CAN transmit queue.
// Depends on ccq_pkg and coalescing_can_tx_queue_unit; needs nothing else.
`timescale 1ns / 100ps

module testbench;
  import ccq_pkg::*;

  typedef struct {
    cmd_e              cmd;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] payload;
    wstat_e            wstat;
  } request_t;

  typedef struct {
    rc_e               code;
    logic              evicted;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] payload;
    logic [RET_W-1:0]  retries;
    logic [BACK_W-1:0] backoff;
  } outcome_t;

  localparam logic [2:0] ADDR_RETRY_LIMIT = 3'd0;
  localparam logic [2:0] ADDR_BACKOFF_CAP = 3'd4;

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic in_done;
  logic [1:0] command, write_status;
  logic [ID_W-1:0] can_id, out_id;
  logic [LEN_W-1:0] length, out_length;
  logic [DATA_W-1:0] payload, out_payload;
  logic [3:0] result_code;
  logic evicted_oldest;
  logic [RET_W-1:0] out_retries;
  logic [BACK_W-1:0] retry_wait;

  coalescing_can_tx_queue_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .can_id_i(can_id), .length_i(length),
    .payload_i(payload), .write_status_i(write_status),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .result_code_o(result_code), .evicted_oldest_o(evicted_oldest),
    .out_id_o(out_id), .out_length_o(out_length), .out_payload_o(out_payload),
    .out_retries_o(out_retries), .retry_wait_o(retry_wait)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // predictor state
  logic [3:0]        retry_limit;
  logic [6:0]        backoff_cap;
  logic              latest_ok [ID_COUNT];
  logic [LEN_W-1:0]  latest_len [ID_COUNT];
  logic [DATA_W-1:0] latest_data [ID_COUNT];
  request_t          tx_queue [$];
  logic [RET_W-1:0]  tx_retries [$];
  logic              flight_ok;
  request_t          flight;
  logic [RET_W-1:0]  flight_retries;

  request_t pending_requests [$];
  outcome_t expected_outcomes [$];
  int send_idle_pct, recv_idle_pct;
  int mismatches;

  function automatic logic [DATA_W-1:0] keep_bytes(logic [LEN_W-1:0] n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic int queue_pos(logic [ID_W-1:0] id);
    foreach (tx_queue[i]) if (tx_queue[i].id == id) return i;
    return -1;
  endfunction

  function automatic logic push_frame(request_t f, logic [RET_W-1:0] r);
    logic dropped;
    dropped = 1'b0;
    if (tx_queue.size() >= QUEUE_DEPTH) begin
      tx_queue.delete(0);
      tx_retries.delete(0);
      dropped = 1'b1;
    end
    tx_queue.insert(tx_queue.size(), f);
    tx_retries.insert(tx_retries.size(), r);
    return dropped;
  endfunction

  function automatic outcome_t predict_outcome(request_t rq);
    outcome_t o;
    request_t f;
    int p;
    int e;
    logic [RET_W-1:0] nr;
    o = '{code: RC_NO_FLIGHT, evicted: 0, id: 0, len: 0, payload: 0, retries: 0,
          backoff: 0};
    case (rq.cmd)
      CMD_SUBMIT: begin
        if (rq.len > 8) o.code = RC_BAD_LENGTH;
        else begin
          f = rq;
          f.payload = rq.payload & keep_bytes(rq.len);
          latest_ok[f.id] = 1'b1;
          latest_len[f.id] = f.len;
          latest_data[f.id] = f.payload;
          p = queue_pos(f.id);
          if (p >= 0) begin
            tx_queue.delete(p);
            tx_retries.delete(p);
          end
          o.evicted = push_frame(f, 0);
          o.code = RC_ACCEPTED;
        end
      end
      CMD_POP: begin
        if (tx_queue.size() == 0) o.code = RC_EMPTY;
        else begin
          flight = tx_queue[0];
          tx_queue.delete(0);
          flight_retries = tx_retries[0];
          tx_retries.delete(0);
          flight_ok = 1'b1;
          o.code = RC_POPPED;
          o.id = flight.id;
          o.len = flight.len;
          o.payload = flight.payload;
          o.retries = flight_retries;
        end
      end
      CMD_STATUS: begin
        if (flight_ok) begin
          flight_ok = 1'b0;
          if (rq.wstat == WS_OK) o.code = RC_SENT;
          else if (rq.wstat == WS_RETRY) begin
            if (flight_retries < retry_limit) begin
              nr = flight_retries + 1;
              e = (nr < 6) ? nr : 6;
              o.backoff = ((1 << e) < backoff_cap) ? (1 << e) : backoff_cap;
              if (latest_ok[flight.id] && latest_len[flight.id] == flight.len &&
                  latest_data[flight.id] == flight.payload &&
                  queue_pos(flight.id) < 0) begin
                o.evicted = push_frame(flight, nr);
                o.code = RC_REQUEUED;
              end else o.code = RC_SUPERSEDED;
            end else o.code = RC_RETRY_LIM;
          end else o.code = RC_FATAL;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // driver: a new request only once the current one has been taken
  always @(negedge clk) begin
    if (!rst_n) in_valid <= 1'b0;
    else if (!in_valid || in_done) begin
      if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t rq;
        rq = pending_requests[0];
        pending_requests.delete(0);
        in_valid <= 1'b1;
        command <= rq.cmd;
        can_id <= rq.id;
        length <= rq.len;
        payload <= rq.payload;
        write_status <= rq.wstat;
      end else in_valid <= 1'b0;
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    in_done <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      request_t rq;
      rq.cmd = cmd_e'(command);
      rq.id = can_id;
      rq.len = length;
      rq.payload = payload;
      rq.wstat = wstat_e'(write_status);
      expected_outcomes.insert(expected_outcomes.size(), predict_outcome(rq));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, code %0d", result_code);
      end else begin
        outcome_t x;
        x = expected_outcomes[0];
        expected_outcomes.delete(0);
        if (result_code !== x.code || evicted_oldest !== x.evicted || out_id !== x.id ||
            out_length !== x.len || out_payload !== x.payload ||
            out_retries !== x.retries || retry_wait !== x.backoff) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: exp code %0d ev %0d id %h len %0d pl %h ret %0d bo %0d",
                     x.code, x.evicted, x.id, x.len, x.payload, x.retries, x.backoff,
                     " / got %0d %0d %h %0d %h %0d %0d", result_code, evicted_oldest,
                     out_id, out_length, out_payload, out_retries, retry_wait);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_RETRY_LIMIT) retry_limit = val[3:0];
    else backoff_cap = val[6:0];
  endtask

  task automatic add_request(cmd_e c, logic [ID_W-1:0] id, logic [LEN_W-1:0] n,
                             logic [DATA_W-1:0] d, wstat_e w);
    request_t rq;
    rq.cmd = c; rq.id = id; rq.len = n; rq.payload = d; rq.wstat = w;
    pending_requests.insert(pending_requests.size(), rq);
  endtask

  // mostly submit/pop/report cycles over a small set of identifiers
  task automatic add_random_batch(int count);
    logic [ID_W-1:0] id;
    repeat (count) begin
      int pick;
      pick = $urandom_range(99);
      id = ($urandom_range(3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(20));
      if (pick < 40)
        add_request(CMD_SUBMIT, id, ($urandom_range(9) == 0) ? LEN_W'($urandom_range(15, 9))
                    : LEN_W'($urandom_range(8)), {$urandom, $urandom}, wstat_e'($urandom));
      else if (pick < 68)
        add_request(CMD_POP, id, LEN_W'($urandom), {$urandom, $urandom}, wstat_e'($urandom));
      else if (pick < 97)
        add_request(CMD_STATUS, id, LEN_W'($urandom), {$urandom, $urandom},
                    ($urandom_range(9) < 6) ? WS_RETRY : wstat_e'($urandom));
      else
        add_request(CMD_NONE, id, LEN_W'($urandom), {$urandom, $urandom}, wstat_e'($urandom));
    end
  endtask

  task automatic drain();
    while (pending_requests.size() > 0 || expected_outcomes.size() > 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; in_done = 0; out_stall = 0; command = 0; can_id = 0; length = 0;
    payload = 0; write_status = 0;
    mismatches = 0;
    retry_limit = 3; backoff_cap = 64;
    foreach (latest_ok[i]) latest_ok[i] = 1'b0;
    flight_ok = 1'b0; flight_retries = 0;
    send_idle_pct = 35; recv_idle_pct = 71;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, every command and corner case
    add_request(CMD_POP, 0, 0, 0, WS_OK);
    add_request(CMD_STATUS, 0, 0, 0, WS_RETRY);
    add_request(CMD_SUBMIT, 11'h7ff, 8, '1, WS_OK);
    add_request(CMD_SUBMIT, 0, 0, '1, WS_BAD);
    add_request(CMD_SUBMIT, 5, 15, '1, WS_OK);
    add_request(CMD_SUBMIT, 5, 9, 64'h0123_4567_89ab_cdef, WS_OK);
    add_request(CMD_SUBMIT, 11'h7ff, 3, 64'hffff_ffff_ffff_ffff, WS_OK);
    add_request(CMD_POP, 0, 0, 0, WS_OK);
    add_request(CMD_POP, 0, 0, 0, WS_OK);
    add_request(CMD_STATUS, 0, 0, 0, WS_RETRY);
    add_request(CMD_POP, 0, 0, 0, WS_OK);
    add_request(CMD_STATUS, 0, 0, 0, WS_BAD);
    add_request(CMD_NONE, 11'h7ff, 15, '1, WS_BAD);
    for (int i = 0; i < 18; i++)
      add_request(CMD_SUBMIT, ID_W'(100 + i), LEN_W'(i % 9), {$urandom, $urandom}, WS_OK);
    drain();

    write_reg(ADDR_RETRY_LIMIT, 0);
    write_reg(ADDR_BACKOFF_CAP, 1);
    add_random_batch(250);
    drain();

    send_idle_pct = 71; recv_idle_pct = 35;
    write_reg(ADDR_RETRY_LIMIT, 15);
    write_reg(ADDR_BACKOFF_CAP, 64);
    add_random_batch(250);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(ADDR_RETRY_LIMIT, 7);
    write_reg(ADDR_BACKOFF_CAP, 13);
    add_random_batch(250);
    drain();

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
